// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the filter unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define BMF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BMF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bmf_pkg
// Types and register indexes of the box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_DIV,
		ST_OUT
	} bmf_state_t;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	localparam int CNT_W   = 23;
	localparam int FW_W    = 11;
	localparam int FH_W    = 13;
	localparam int FR_W    = 2;
	localparam int MAX_H   = 4096;

endpackage

// ===== rtl/bmf_ram.sv =====
// ----------------------------------------------------------------------------
// bmf_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 7175
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/box_mean_filter_zero_pad_unit.sv =====
// ----------------------------------------------------------------------------
// box_mean_filter_zero_pad_unit
// Streaming box mean filter with zero padding over a circular line store.
// ----------------------------------------------------------------------------
// Input words (req_type, pixel_in) arrive in raster order on in_valid/in_ready;
// result words (pixel_out, frame_last) leave on out_valid/out_ready.
// A pixel word is written into the line store; once r*W+r later pixels have
// followed, it yields the mean of the window of an earlier pixel. After the
// frame, drain words flush the remaining results one per word.
// A word without result ends with its acceptance. A word with result passes
// the accept state, (2r+1)^2 reads of the single store read port, a wait
// state for the read data, the SUM_W-bit shift-subtract divider and the
// output state.
// in_ready is high only while no word is in work. A finished result waits
// in the output register; the next word is taken meanwhile, but its result
// waits until out_ready frees that register.
// Reset: W=1024 (clamped to MAX_WIDTH), H=1024, r=1, counters zero.
// A write to the width, height or radius register restarts the frame; after
// any configuration write in_ready stays low while the frame geometry settles.
// ----------------------------------------------------------------------------
module box_mean_filter_zero_pad_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    req_type,
	input  logic [7:0]              pixel_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [7:0]              pixel_out,
	output logic                    frame_last,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [bmf_pkg::FH_W-1:0] cfg_data
);
	import bmf_pkg::*;

	localparam int DEPTH   = (2 * MAX_RADIUS + 1) * (MAX_WIDTH + 1);
	localparam int AW      = $clog2(DEPTH);
	localparam int SW      = AW + 2;
	localparam int SIDE_MX = 2 * MAX_RADIUS + 1;
	localparam int SQ_W    = $clog2(SIDE_MX * SIDE_MX + 1);
	localparam int SUM_W   = $clog2(SIDE_MX * SIDE_MX * 255 + 1);
	localparam int DC_W    = $clog2(SUM_W + 1);
	localparam int RST_W   = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
	localparam int RST_R   = (1 > MAX_RADIUS) ? MAX_RADIUS : 1;

	bmf_state_t state_q, state_d;

	logic [FW_W-1:0]  cfg_w_q, eff_w_q;
	logic [FH_W-1:0]  cfg_h_q, eff_h_q;
	logic [FR_W-1:0]  cfg_r_q, eff_r_q;
	logic [CNT_W-1:0] total_q;
	logic [AW-1:0]    delay_q;
	logic [SQ_W-1:0]  sq_q;
	logic [1:0]       cfg_wait_q;

	logic [CNT_W-1:0] in_cnt_q, out_cnt_q;
	logic [AW-1:0]    wr_ptr_q, out_ptr_q;
	logic [FH_W-1:0]  row_q;
	logic [FW_W-1:0]  col_q;

	logic [FR_W:0]    di_q, dj_q;
	logic signed [FH_W+1:0] y_q;
	logic signed [FW_W+1:0] x_q;
	logic [AW-1:0]    ra_q;
	logic             act_s1, msk_s1, last_s1;
	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]  rem_q;
	logic [DC_W-1:0]  dcnt_q;

	logic [7:0]       rd_data;
	logic             acc, emit, st_we, win_last, win_msk, out_load, out_end;
	logic [FR_W:0]    span;
	logic [SQ_W:0]    rem_sh;

	function automatic logic [AW-1:0] wrap(input logic signed [SW-1:0] a);
		logic signed [SW-1:0] t;
		t = a;
		if (a < 0) begin
			t = a + SW'(DEPTH);
		end else if (a >= SW'(DEPTH)) begin
			t = a - SW'(DEPTH);
		end
		return t[AW-1:0];
	endfunction

	assign acc      = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && (cfg_wait_q == '0);
	assign span     = {eff_r_q, 1'b0};
	assign win_last = (di_q == span) && (dj_q == span);
	assign win_msk  = (y_q >= 0) && (y_q < $signed({2'b00, eff_h_q}))
		&& (x_q >= 0) && (x_q < $signed({2'b00, eff_w_q}));
	assign rem_sh   = {rem_q, sum_q[SUM_W-1]};
	assign out_load = (state_q == ST_OUT) && (!out_valid || out_ready);
	assign out_end  = (out_cnt_q + 1'b1) == total_q;

	always_comb begin
		emit  = 1'b0;
		st_we = 1'b0;
		if (acc) begin
			if (req_type == REQ_PIXEL) begin
				if (in_cnt_q < total_q) begin
					st_we = 1'b1;
					emit  = (in_cnt_q + 1'b1 - out_cnt_q) > CNT_W'(delay_q);
				end
			end else begin
				emit = (in_cnt_q == total_q) && (out_cnt_q < total_q);
			end
		end
	end

	bmf_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(wr_ptr_q),
		.wdata(pixel_in),
		.raddr(ra_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (emit) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (win_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (dcnt_q == DC_W'(1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration and derived frame geometry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q    <= FW_W'(1024);
			cfg_h_q    <= FH_W'(1024);
			cfg_r_q    <= FR_W'(1);
			eff_w_q    <= FW_W'(RST_W);
			eff_h_q    <= FH_W'(1024);
			eff_r_q    <= FR_W'(RST_R);
			total_q    <= CNT_W'(RST_W * 1024);
			delay_q    <= AW'(RST_R * RST_W + RST_R);
			sq_q       <= SQ_W'((2 * RST_R + 1) * (2 * RST_R + 1));
			cfg_wait_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH:  cfg_w_q <= cfg_data[FW_W-1:0];
					REG_HEIGHT: cfg_h_q <= cfg_data;
					REG_RADIUS: cfg_r_q <= cfg_data[FR_W-1:0];
					default: ;
				endcase
			end
			// geometry follows a write through the cfg and eff registers; cfg_wait_q holds in_ready low meanwhile
			if (cfg_we) begin
				cfg_wait_q <= 2'd2;
			end else if (cfg_wait_q != '0) begin
				cfg_wait_q <= cfg_wait_q - 1'b1;
			end
			if (cfg_w_q == '0) begin
				eff_w_q <= FW_W'(1);
			end else if (int'(cfg_w_q) > MAX_WIDTH) begin
				eff_w_q <= FW_W'(MAX_WIDTH);
			end else begin
				eff_w_q <= cfg_w_q;
			end
			if (cfg_h_q == '0) begin
				eff_h_q <= FH_W'(1);
			end else if (int'(cfg_h_q) > MAX_H) begin
				eff_h_q <= FH_W'(MAX_H);
			end else begin
				eff_h_q <= cfg_h_q;
			end
			if (int'(cfg_r_q) > MAX_RADIUS) begin
				eff_r_q <= FR_W'(MAX_RADIUS);
			end else begin
				eff_r_q <= cfg_r_q;
			end
			total_q <= CNT_W'(eff_w_q) * CNT_W'(eff_h_q);
			delay_q <= AW'(eff_r_q) * AW'(eff_w_q) + AW'(eff_r_q);
			sq_q    <= SQ_W'({eff_r_q, 1'b1}) * SQ_W'({eff_r_q, 1'b1});
		end
	end

	// frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			wr_ptr_q  <= '0;
			out_ptr_q <= '0;
			row_q     <= '0;
			col_q     <= '0;
		end else if (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
				|| cfg_index == REG_RADIUS)) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			wr_ptr_q  <= '0;
			out_ptr_q <= '0;
			row_q     <= '0;
			col_q     <= '0;
		end else begin
			if (st_we) begin
				in_cnt_q <= in_cnt_q + 1'b1;
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (out_load) begin
				if (out_end) begin
					in_cnt_q  <= '0;
					out_cnt_q <= '0;
					wr_ptr_q  <= '0;
					out_ptr_q <= '0;
					row_q     <= '0;
					col_q     <= '0;
				end else begin
					out_cnt_q <= out_cnt_q + 1'b1;
					out_ptr_q <= (int'(out_ptr_q) == DEPTH - 1) ? '0 : out_ptr_q + 1'b1;
					if (col_q == eff_w_q - 1'b1) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

	// window walk, read pipeline, accumulate, divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			dcnt_q <= '0;
		end else begin
			act_s1 <= (state_q == ST_RUN);
			if (state_q == ST_DIV) begin
				dcnt_q <= dcnt_q - 1'b1;
			end else if (state_q == ST_WAIT) begin
				dcnt_q <= DC_W'(SUM_W);
			end
		end
	end

	always_ff @(posedge clk) begin
		msk_s1  <= win_msk;
		last_s1 <= win_last;
		unique case (state_q)
			ST_IDLE: begin
				di_q  <= '0;
				dj_q  <= '0;
				y_q   <= $signed({2'b00, row_q}) - $signed({{FH_W{1'b0}}, eff_r_q});
				x_q   <= $signed({2'b00, col_q}) - $signed({{FW_W{1'b0}}, eff_r_q});
				ra_q  <= wrap($signed({2'b00, out_ptr_q}) - $signed({2'b00, delay_q}));
				sum_q <= '0;
			end
			ST_RUN: begin
				if (dj_q == span) begin
					dj_q <= '0;
					di_q <= di_q + 1'b1;
					y_q  <= y_q + 1'b1;
					x_q  <= $signed({2'b00, col_q}) - $signed({{FW_W{1'b0}}, eff_r_q});
					ra_q <= wrap($signed({2'b00, ra_q}) + $signed(SW'(eff_w_q))
						- $signed(SW'(span)));
				end else begin
					dj_q <= dj_q + 1'b1;
					x_q  <= x_q + 1'b1;
					ra_q <= wrap($signed({2'b00, ra_q}) + $signed(SW'(1)));
				end
				if (act_s1 && msk_s1) begin
					sum_q <= sum_q + SUM_W'(rd_data);
				end
			end
			ST_WAIT: begin
				rem_q <= '0;
				if (act_s1 && msk_s1) begin
					sum_q <= sum_q + SUM_W'(rd_data);
				end
			end
			ST_DIV: begin
				if (rem_sh >= {1'b0, sq_q}) begin
					rem_q <= SQ_W'(rem_sh - {1'b0, sq_q});
					sum_q <= {sum_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[SQ_W-1:0];
					sum_q <= {sum_q[SUM_W-2:0], 1'b0};
				end
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_out  <= sum_q[7:0];
			frame_last <= out_end;
		end
	end

	`include "assert_macros.svh"

	`BMF_ASSERT(a_out_behind_in, out_cnt_q <= in_cnt_q, "output count passed input count")
	`BMF_ASSERT(a_rise_from_out, $rose(out_valid) |-> $past(state_q == ST_OUT), "result without computation")
	`BMF_ASSERT(a_ptr_range, int'(wr_ptr_q) < DEPTH && int'(out_ptr_q) < DEPTH, "store pointer out of range")
	`BMF_ASSERT(a_last_read, act_s1 && last_s1 |-> state_q == ST_WAIT, "window read count mismatch")

endmodule
